// ----- rtl/core/wsed_pkg.sv -----
// ----------------------------------------------------------------------------
// wsed_pkg
// Shared widths, register codes, FSM states and control structs of the
// windowed saturation exit detector.
// ----------------------------------------------------------------------------
package wsed_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int SAT_W      = 8;
    localparam int TS_W       = 32;
    localparam int TERM_W     = SAT_W + TS_W;     // one sample times one interval
    localparam int AREA_W     = 44;
    localparam int ATTEN_W    = 16;
    localparam int COUNT_W    = 4;
    localparam int UNITY_SHIFT = 14;               // Q2.14: 1.0 = 1 << 14
    localparam int HALF_W     = AREA_W / 2;        // peak split for the multiply
    localparam int PROD_W     = ATTEN_W + HALF_W;
    localparam int CMP_W      = ATTEN_W + AREA_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ATTEN_W;

    localparam int S_TDATA_W  = ((SAT_W + TS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + AREA_W + AREA_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [AREA_W-1:0]    AREA_MAX    = {AREA_W{1'b1}};
    localparam logic [ATTEN_W-1:0]   ATTEN_RESET = ATTEN_W'(1 << UNITY_SHIFT);

    localparam logic [CFG_IDX_W-1:0] REG_ATTEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_ACC,
        ST_PEAK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FIN
    } wsed_state_t;

    typedef struct packed {
        logic load;     // take the new sample
        logic shift;    // take the neighbor's entry
    } wsed_cell_ctrl_t;

    typedef struct packed {
        logic clear;    // start a new area
        logic step;     // head of the ring moved on
        logic use_term; // head entry contributes a term
    } wsed_acc_ctrl_t;

endpackage

// ----- rtl/core/wsed_cell.sv -----
// ----------------------------------------------------------------------------
// wsed_cell
// One window entry: saturation and timestamp, loaded from the input or
// handed over from the neighbor cell.
// ----------------------------------------------------------------------------
module wsed_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wsed_pkg::wsed_cell_ctrl_t   ctrl,
    input  logic [wsed_pkg::SAT_W-1:0]  load_sat,
    input  logic [wsed_pkg::TS_W-1:0]   load_tstamp,
    input  logic [wsed_pkg::SAT_W-1:0]  nbr_sat,
    input  logic [wsed_pkg::TS_W-1:0]   nbr_tstamp,
    output logic [wsed_pkg::SAT_W-1:0]  sat,
    output logic [wsed_pkg::TS_W-1:0]   tstamp
);

    logic [wsed_pkg::SAT_W-1:0] sat_reg;
    logic [wsed_pkg::SAT_W-1:0] sat_next;
    logic [wsed_pkg::TS_W-1:0]  tstamp_reg;
    logic [wsed_pkg::TS_W-1:0]  tstamp_next;

    always_comb
    begin
        sat_next    = sat_reg;
        tstamp_next = tstamp_reg;
        if (ctrl.load)
        begin
            sat_next    = load_sat;
            tstamp_next = load_tstamp;
        end
        else if (ctrl.shift)
        begin
            sat_next    = nbr_sat;
            tstamp_next = nbr_tstamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg    <= '0;
            tstamp_reg <= '0;
        end
        else
        begin
            sat_reg    <= sat_next;
            tstamp_reg <= tstamp_next;
        end
    end

    assign sat    = sat_reg;
    assign tstamp = tstamp_reg;

endmodule

// ----- rtl/core/wsed_area_acc.sv -----
// ----------------------------------------------------------------------------
// wsed_area_acc
// Watches the head of the cell ring, forms sample * interval terms and
// sums them with saturation.
// ----------------------------------------------------------------------------
module wsed_area_acc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wsed_pkg::wsed_acc_ctrl_t    ctrl,
    input  logic [wsed_pkg::SAT_W-1:0]  head_sat,
    input  logic [wsed_pkg::TS_W-1:0]   head_tstamp,
    output logic [wsed_pkg::AREA_W-1:0] area
);

    logic [wsed_pkg::TS_W-1:0]   prev_tstamp_reg;
    logic [wsed_pkg::TS_W-1:0]   interval;
    logic [wsed_pkg::TERM_W-1:0] term_reg;
    logic                        term_vld_reg;
    logic [wsed_pkg::AREA_W-1:0] area_reg;
    logic [wsed_pkg::AREA_W:0]   sum;

    // interval wraps modulo 2^32
    assign interval = head_tstamp - prev_tstamp_reg;
    assign sum      = {1'b0, area_reg} + (wsed_pkg::AREA_W + 1)'(term_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            prev_tstamp_reg <= head_tstamp;
            term_reg        <= wsed_pkg::TERM_W'(head_sat) * wsed_pkg::TERM_W'(interval);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_vld_reg <= 1'b0;
            area_reg     <= '0;
        end
        else
        begin
            term_vld_reg <= ctrl.step && ctrl.use_term && !ctrl.clear;
            if (ctrl.clear)
                area_reg <= '0;
            else if (term_vld_reg)
                area_reg <= sum[wsed_pkg::AREA_W] ? wsed_pkg::AREA_MAX
                                                  : sum[wsed_pkg::AREA_W-1:0];
        end
    end

    assign area = area_reg;

endmodule

// ----- rtl/core/windowed_saturation_exit_detector_core.sv -----
// ----------------------------------------------------------------------------
// windowed_saturation_exit_detector_core
// Sliding-window time-weighted saturation area with peak tracking and
// ratio-based exit flag.
// ----------------------------------------------------------------------------
// Sequence: the result follows the input transfer after one full ring
//   rotation, accumulate, peak, two multiply steps and compare.
// Items: one in work at a time, no new input until the result is handed to
//   the output register, paced by the ring rotation past the single term multiplier.
// Reset (rst_n, async, low): window cells, peak, fill index cleared;
//   attenuation_ratio = 1.0 (16384), window_count = 0.
// ----------------------------------------------------------------------------
module windowed_saturation_exit_detector_core #(
    parameter int WINDOW_DEPTH = wsed_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [wsed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsed_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: saturation_sample[7:0], sample_time[31:0]
    input  logic [wsed_pkg::S_TDATA_W-1:0]    s_tdata,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: exit_detected, window_area[43:0], peak_area[43:0], zero pad
    output logic [wsed_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int FW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = (FW > wsed_pkg::COUNT_W) ? FW : wsed_pkg::COUNT_W;
    localparam int PAD_W = wsed_pkg::M_TDATA_W - wsed_pkg::M_FIELDS_W;
    localparam logic [FW-1:0] LAST_POS = FW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(WINDOW_DEPTH - 1);

    // ---------------- configuration registers ----------------
    logic [wsed_pkg::ATTEN_W-1:0] atten_reg;
    logic [wsed_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atten_reg <= wsed_pkg::ATTEN_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsed_pkg::REG_ATTEN: atten_reg <= cfg_data;
                wsed_pkg::REG_COUNT: count_reg <= cfg_data[wsed_pkg::COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // ---------------- input fields ----------------
    logic [wsed_pkg::SAT_W-1:0] in_sat;
    logic [wsed_pkg::TS_W-1:0]  in_tstamp;
    logic                       s_xfer;

    assign in_sat    = s_tdata[wsed_pkg::SAT_W-1:0];
    assign in_tstamp = s_tdata[wsed_pkg::SAT_W +: wsed_pkg::TS_W];
    assign s_xfer    = s_tvalid && s_tready;

    // ---------------- control state ----------------
    wsed_pkg::wsed_state_t state_reg, state_next;
    logic [FW-1:0] fill_reg,  fill_next;
    logic [FW-1:0] pos_reg,   pos_next;     // ring position at the head cell
    logic          full_reg,  full_next;    // window full for this item
    logic          out_vld_reg, out_vld_next;

    // count clamped to depth - 1, fill index clamped to count
    logic [CW-1:0] cnt_wide;
    logic [FW-1:0] cnt_eff;
    logic [FW-1:0] fill_eff;

    assign cnt_wide = (CW'(count_reg) > CNT_MAX) ? CNT_MAX : CW'(count_reg);
    assign cnt_eff  = cnt_wide[FW-1:0];
    assign fill_eff = (fill_reg > cnt_eff) ? cnt_eff : fill_reg;

    // ---------------- datapath registers ----------------
    logic [wsed_pkg::AREA_W-1:0] peak_reg, peak_next;
    logic [wsed_pkg::PROD_W-1:0] prod_lo_reg;
    logic [wsed_pkg::PROD_W-1:0] prod_hi_reg;
    logic                        out_exit_reg;
    logic [wsed_pkg::AREA_W-1:0] out_area_reg;
    logic [wsed_pkg::AREA_W-1:0] out_peak_reg;
    logic [wsed_pkg::AREA_W-1:0] area;

    // ---------------- cell chain ----------------
    logic                      load_en;
    logic                      rot_en;
    logic                      slide_en;
    wsed_pkg::wsed_cell_ctrl_t cell_ctrl [WINDOW_DEPTH];
    logic [wsed_pkg::SAT_W-1:0] cell_sat    [WINDOW_DEPTH];
    logic [wsed_pkg::TS_W-1:0]  cell_tstamp [WINDOW_DEPTH];

    // The chain is a ring: cell j takes cell j+1. A full rotation walks every
    // entry past cell 0 and leaves the window where it started. A slide moves
    // only the cells below the fill index, dropping the oldest sample.
    for (genvar j = 0; j < WINDOW_DEPTH; j++)
    begin : g_cell
        localparam int NB = (j + 1) % WINDOW_DEPTH;

        always_comb
        begin
            cell_ctrl[j].load  = load_en && (fill_eff == FW'(j));
            cell_ctrl[j].shift = rot_en || (slide_en && (FW'(j) < fill_reg));
        end

        wsed_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl[j]),
            .load_sat    (in_sat),
            .load_tstamp (in_tstamp),
            .nbr_sat     (cell_sat[NB]),
            .nbr_tstamp  (cell_tstamp[NB]),
            .sat         (cell_sat[j]),
            .tstamp      (cell_tstamp[j])
        );
    end

    // ---------------- area accumulator ----------------
    wsed_pkg::wsed_acc_ctrl_t acc_ctrl;

    wsed_area_acc u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (acc_ctrl),
        .head_sat    (cell_sat[0]),
        .head_tstamp (cell_tstamp[0]),
        .area        (area)
    );

    // ---------------- exit compare ----------------
    logic [wsed_pkg::CMP_W-1:0] lhs;
    logic [wsed_pkg::CMP_W-1:0] rhs;
    logic                       exit_flag;

    // area * 1.0 versus attenuation * peak, peak multiplied in two halves
    assign lhs = wsed_pkg::CMP_W'(area) << wsed_pkg::UNITY_SHIFT;
    assign rhs = (wsed_pkg::CMP_W'(prod_hi_reg) << wsed_pkg::HALF_W)
               + wsed_pkg::CMP_W'(prod_lo_reg);
    assign exit_flag = full_reg && (peak_reg != '0) && (lhs < rhs);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        full_next    = full_reg;
        out_vld_next = out_vld_reg;
        peak_next    = peak_reg;
        load_en      = 1'b0;
        rot_en       = 1'b0;
        slide_en     = 1'b0;
        acc_ctrl     = '0;
        s_tready     = 1'b0;

        if (out_vld_reg && m_tready)
            out_vld_next = 1'b0;

        case (state_reg)
            wsed_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    load_en        = 1'b1;
                    acc_ctrl.clear = 1'b1;
                    fill_next      = fill_eff;
                    full_next      = (fill_eff == cnt_eff);
                    pos_next       = '0;
                    state_next     = wsed_pkg::ST_ROT;
                end
            end
            wsed_pkg::ST_ROT:
            begin
                rot_en            = 1'b1;
                acc_ctrl.step     = 1'b1;
                acc_ctrl.use_term = (pos_reg != '0) && (pos_reg <= fill_reg);
                pos_next          = pos_reg + FW'(1);
                if (pos_reg == LAST_POS)
                begin
                    pos_next   = '0;
                    state_next = wsed_pkg::ST_ACC;
                end
            end
            wsed_pkg::ST_ACC:
            begin
                state_next = wsed_pkg::ST_PEAK;
            end
            wsed_pkg::ST_PEAK:
            begin
                if ((fill_reg != '0) && (area > peak_reg))
                    peak_next = area;
                if (full_reg)
                    slide_en = 1'b1;
                else
                    fill_next = fill_reg + FW'(1);
                state_next = wsed_pkg::ST_MUL_LO;
            end
            wsed_pkg::ST_MUL_LO:
            begin
                state_next = wsed_pkg::ST_MUL_HI;
            end
            wsed_pkg::ST_MUL_HI:
            begin
                state_next = wsed_pkg::ST_FIN;
            end
            wsed_pkg::ST_FIN:
            begin
                // hand over once the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    state_next   = wsed_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsed_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wsed_pkg::ST_IDLE;
            fill_reg    <= '0;
            pos_reg     <= '0;
            full_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            peak_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            full_reg    <= full_next;
            out_vld_reg <= out_vld_next;
            peak_reg    <= peak_next;
        end
    end

    // multiply steps and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == wsed_pkg::ST_MUL_LO)
            prod_lo_reg <= wsed_pkg::PROD_W'(atten_reg)
                         * wsed_pkg::PROD_W'(peak_reg[wsed_pkg::HALF_W-1:0]);
        if (state_reg == wsed_pkg::ST_MUL_HI)
            prod_hi_reg <= wsed_pkg::PROD_W'(atten_reg)
                         * wsed_pkg::PROD_W'(peak_reg[wsed_pkg::AREA_W-1:wsed_pkg::HALF_W]);
        if ((state_reg == wsed_pkg::ST_FIN) && (!out_vld_reg || m_tready))
        begin
            out_exit_reg <= exit_flag;
            out_area_reg <= area;
            out_peak_reg <= peak_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_peak_reg, out_area_reg, out_exit_reg};

endmodule

// ----- rtl/core/wsed_checker.sv -----
// ----------------------------------------------------------------------------
// wsed_checker
// Port-level checks of the exit detector, bound to the top level.
// ----------------------------------------------------------------------------
module wsed_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wsed_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [wsed_pkg::AREA_W-1:0] chk_area;
    logic [wsed_pkg::AREA_W-1:0] chk_peak;

    assign chk_area = m_tdata[wsed_pkg::AREA_W:1];
    assign chk_peak = m_tdata[2*wsed_pkg::AREA_W:wsed_pkg::AREA_W+1];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // peak never falls below the area reported with it
    a_peak_ge_area: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_area <= chk_peak)
        else $error("window area above peak");

    // exit needs a nonzero peak
    a_exit_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> chk_peak != '0)
        else $error("exit flagged with zero peak");

endmodule

bind windowed_saturation_exit_detector_core wsed_checker u_wsed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
